// File: rtl/avmx_pkg.sv
package avmx_pkg;

   localparam int ACTION_W = 4;
   localparam int WORD_W   = 64;
   localparam int INDEX_W  = 3;
   localparam int BLOCK_W  = 6;

   // request payload: 86 bits of fields, padded to 11 bytes
   localparam int REQ_FIELDS_W = ACTION_W + WORD_W + 2 * INDEX_W + 2 * BLOCK_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;

   // response payload: 73 bits of fields, padded to 10 bytes
   localparam int RSP_FIELDS_W = WORD_W + 1 + BLOCK_W + 1 + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [ACTION_W-1:0] {
      OP_EXIT     = 4'd0,
      OP_LOADIMM  = 4'd1,
      OP_LOAD     = 4'd2,
      OP_STORE    = 4'd3,
      OP_SETLOCAL = 4'd4,
      OP_GETLOCAL = 4'd5,
      OP_INC      = 4'd6,
      OP_JUMP     = 4'd7,
      OP_JUMPCOND = 4'd8,
      OP_LESSTHAN = 4'd9
   } opcode_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]  zero_block;
      logic [BLOCK_W-1:0]  taken_block;
      logic [INDEX_W-1:0]  local_index;
      logic [INDEX_W-1:0]  reg_index;
      logic [WORD_W-1:0]   immediate;
      logic [ACTION_W-1:0] action;
   } req_type;

   typedef struct packed {
      logic                bad_opcode;
      logic                halt;
      logic [BLOCK_W-1:0]  next_block;
      logic                redirect;
      logic [WORD_W-1:0]   accumulator;
   } rsp_type;

endpackage

// File: rtl/accumulator_vm_execute.sv
// Execute stage of a small accumulator machine. Each request on req_ is one
// decoded instruction; each produces exactly one response on rsp_ carrying the
// accumulator (register 0) after the instruction, a redirect flag and target
// block for jumps, a halt flag for exit and a flag for an unknown opcode. The
// register file and the local slots live in flip-flops and are cleared by
// reset. An instruction first sits in the input register, where its
// register-file read, 64-bit increment or compare and state write all happen,
// then in the response register: one instruction per cycle sustained as long
// as rsp_tready stays high. The next instruction sees the state left by
// the previous one with no bubble. A register or local index beyond the
// configured count reads as zero and ignores writes; jump targets are taken
// modulo MAX_BLOCKS.
module accumulator_vm_execute #(
   parameter int NUM_REGS   = 8,
   parameter int NUM_LOCALS = 8,
   parameter int MAX_BLOCKS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // low to high: action[4], immediate[64], reg_index[3], local_index[3],
   // taken_block[6], zero_block[6], zero pad
   input  logic [avmx_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // low to high: accumulator[64], redirect[1], next_block[6], halt[1],
   // bad_opcode[1], zero pad
   output logic [avmx_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // only indexes 0..7 are reachable through the 3-bit fields
   localparam int REG_DEPTH = (NUM_REGS < 8) ? NUM_REGS : 8;
   localparam int LOC_DEPTH = (NUM_LOCALS < 8) ? NUM_LOCALS : 8;
   localparam int RIDX_W    = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
   localparam int LIDX_W    = (LOC_DEPTH > 1) ? $clog2(LOC_DEPTH) : 1;
   localparam int NUM_TGT   = 1 << avmx_pkg::BLOCK_W;

   // input stage
   logic              req_valid_ff;
   avmx_pkg::req_type req_ff;
   // response stage
   logic              rsp_valid_ff;
   avmx_pkg::rsp_type rsp_ff, rsp_in;

   // machine state
   logic [avmx_pkg::WORD_W-1:0] regs_ff [REG_DEPTH];
   logic [avmx_pkg::WORD_W-1:0] locals_ff [LOC_DEPTH];

   // jump target table, target modulo MAX_BLOCKS folded at elaboration
   logic [avmx_pkg::BLOCK_W-1:0] blk_tbl [NUM_TGT];
   for (genvar k = 0; k < NUM_TGT; k++) begin : g_blk
      assign blk_tbl[k] = avmx_pkg::BLOCK_W'(k % MAX_BLOCKS);
   end

   logic                           exec;
   logic                           reg_ok, loc_ok;
   logic [RIDX_W-1:0]              ridx;
   logic [LIDX_W-1:0]              lidx;
   logic [avmx_pkg::WORD_W-1:0]    acc, reg_rd, loc_rd, acc_in;
   logic                           reg_we, loc_we, acc_we;
   logic [avmx_pkg::BLOCK_W-1:0]   tgt;
   avmx_pkg::opcode_type           op;

   // the instruction in the input register executes when the response
   // register is free or is being emptied this cycle
   assign exec       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || exec;

   assign op     = avmx_pkg::opcode_type'(req_ff.action);
   assign reg_ok = 32'(req_ff.reg_index) < NUM_REGS;
   assign loc_ok = 32'(req_ff.local_index) < NUM_LOCALS;
   assign ridx   = req_ff.reg_index[RIDX_W-1:0];
   assign lidx   = req_ff.local_index[LIDX_W-1:0];
   assign acc    = regs_ff[0];
   assign reg_rd = reg_ok ? regs_ff[ridx] : '0;
   assign loc_rd = loc_ok ? locals_ff[lidx] : '0;

   always_comb begin
      acc_in  = acc;
      reg_we  = 1'b0;
      loc_we  = 1'b0;
      tgt     = '0;
      rsp_in  = '0;
      unique case (op)
         avmx_pkg::OP_EXIT: begin
            rsp_in.halt = 1'b1;
         end
         avmx_pkg::OP_LOADIMM: begin
            acc_in = req_ff.immediate;
         end
         avmx_pkg::OP_LOAD: begin
            acc_in = reg_rd;
         end
         avmx_pkg::OP_STORE: begin
            reg_we = reg_ok;
         end
         avmx_pkg::OP_SETLOCAL: begin
            loc_we = loc_ok;
         end
         avmx_pkg::OP_GETLOCAL: begin
            acc_in = loc_rd;
         end
         avmx_pkg::OP_INC: begin
            acc_in = acc + avmx_pkg::WORD_W'(1);
         end
         avmx_pkg::OP_JUMP: begin
            rsp_in.redirect = 1'b1;
            tgt             = req_ff.taken_block;
         end
         avmx_pkg::OP_JUMPCOND: begin
            rsp_in.redirect = 1'b1;
            tgt             = (acc != '0) ? req_ff.taken_block : req_ff.zero_block;
         end
         avmx_pkg::OP_LESSTHAN: begin
            acc_in = {{(avmx_pkg::WORD_W-1){1'b0}}, (reg_rd < acc)};
         end
         default: begin
            rsp_in.bad_opcode = 1'b1;
         end
      endcase
      rsp_in.next_block  = rsp_in.redirect ? blk_tbl[tgt] : '0;
      // a store leaves register 0 alone, even a store to register 0
      rsp_in.accumulator = reg_we ? acc : acc_in;
   end

   assign acc_we = exec && !reg_we && (op != avmx_pkg::OP_STORE);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < REG_DEPTH; i++) begin
            regs_ff[i] <= '0;
         end
         for (int i = 0; i < LOC_DEPTH; i++) begin
            locals_ff[i] <= '0;
         end
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (acc_we) begin
            regs_ff[0] <= acc_in;
         end
         if (exec && reg_we && (ridx != '0)) begin
            regs_ff[ridx] <= acc;
         end
         if (exec && loc_we) begin
            locals_ff[lidx] <= acc;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_ff <= req_tdata[avmx_pkg::REQ_FIELDS_W-1:0];
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = avmx_pkg::RSP_DATA_W'(rsp_ff);

   // an executed instruction always lands in the response register
   a_exec_to_rsp: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid_ff)
      else $error("executed instruction produced no response");

   // a store never changes the accumulator
   a_store_keeps_acc: assert property (@(posedge clock) disable iff (reset)
      (exec && op == avmx_pkg::OP_STORE) |=> (regs_ff[0] == $past(regs_ff[0])))
      else $error("store changed register 0");

   // next_block is zero unless a redirect is reported
   a_no_redirect_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.redirect) |-> (rsp_ff.next_block == '0))
      else $error("next_block set without redirect");

   // response accumulator matches register 0 right after execution
   a_acc_matches: assert property (@(posedge clock) disable iff (reset)
      exec |=> (rsp_ff.accumulator == regs_ff[0]))
      else $error("reported accumulator differs from register 0");

endmodule
